// ===== rtl/lbrs_pkg.sv =====
// Package with shared types and constants for the logarithm by repeated square root block.
package lbrs_pkg;

  localparam int unsigned WORD_W = 64;
  localparam logic [WORD_W-1:0] ONE_INT = 64'h0000_0001_0000_0000;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_DOMAIN = 2'd1;
  localparam logic [1:0] STAT_RANGE  = 2'd2;

  typedef enum logic {
    OP_SQRT,
    OP_DIV
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SQRT_GO,
    ST_SQRT_WAIT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FINISH
  } state_t;

endpackage

// ===== rtl/log_by_repeated_square_root.sv =====
// Top level of the natural logarithm by repeated square root block.
//
//   channel   direction  signals
//   input     in         in_valid, in_ready, operand
//   result    out        out_valid, out_ready, log_value, status
//   config    in         cfg_wr_en, cfg_wr_data (tolerance)
//
// One beat in gives one beat out. A round is one square root of 48 steps and
// one division of 97 steps on the shared bit-serial unit, plus the sequencer
// states; an item takes at most MAX_ITER rounds, and negative and zero
// operands go straight from the idle state to the finish state.
// Reset is synchronous and active high; it clears the sequencer, the output
// valid and sets the tolerance to 1. The input is taken only in the idle
// state; a finished result waits in the output register, and the next item
// is taken meanwhile, stalling only at its own finish if the output is full.
module log_by_repeated_square_root import lbrs_pkg::*; #(
  parameter int MAX_ITER  = 40,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] operand,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] log_value,
  output logic [1:0]  status,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  localparam int INT_SHIFT = 32 - FRAC_BITS;
  localparam int N_W = $clog2(MAX_ITER + 1);
  localparam logic [N_W-1:0] N_MAX = N_W'(MAX_ITER);

  // The tolerance register, written whenever the enable is high.
  logic [15:0] tolerance;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= 16'd1;
    end else if (cfg_wr_en) begin
      tolerance <= cfg_wr_data;
    end
  end

  state_t state, state_next;

  // Working values: x is the repeatedly rooted operand, mag the magnitude of r.
  logic [WORD_W-1:0] x, mag;
  logic              neg;
  logic [1:0]        stat_r;
  logic [N_W-1:0]    n;

  unit_req_t         req;
  unit_stat_t        ustat;
  logic [WORD_W-1:0] ures;
  logic [WORD_W-1:0] usrc, udiv;

  lbrs_unit u_unit (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .src     (usrc),
    .divisor (udiv),
    .stat    (ustat),
    .result  (ures)
  );

  assign usrc = (state == ST_SQRT_GO) ? x : mag;
  assign udiv = ONE_INT + x;

  // Deviation of x from one, used for the stop test.
  logic [WORD_W-1:0] dev;
  assign dev = (x > ONE_INT) ? (x - ONE_INT) : (ONE_INT - x);

  // Operand scaled to 32 fraction bits; only used for positive operands.
  logic [WORD_W-1:0] x_init;
  assign x_init = WORD_W'({1'b0, operand[30:0]}) << INT_SHIFT;

  // Final truncation, saturation and sign.
  logic [WORD_W-1:0] q;
  logic [31:0]       fin_value;
  always_comb begin
    q = mag >> INT_SHIFT;
    if (stat_r == STAT_DOMAIN) begin
      fin_value = 32'd0;
    end else if (stat_r == STAT_RANGE) begin
      fin_value = 32'h8000_0000;
    end else if (!neg) begin
      fin_value = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    end else begin
      fin_value = (q > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - q[31:0]);
    end
  end

  logic out_free;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    req.start  = 1'b0;
    req.op     = OP_SQRT;
    in_ready   = (state == ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (operand[31] || operand == 32'd0) ? ST_FINISH : ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (dev <= WORD_W'(tolerance) || n == N_MAX) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_SQRT_GO;
        end
      end
      ST_SQRT_GO: begin
        req.start  = 1'b1;
        req.op     = OP_SQRT;
        state_next = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: begin
        if (ustat.done) begin
          state_next = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        req.start  = 1'b1;
        req.op     = OP_DIV;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (ustat.done) begin
          state_next = ST_CHECK;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers of the sequencer.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      n      <= '0;
      x      <= x_init;
      neg    <= (x_init < ONE_INT);
      mag    <= (x_init >= ONE_INT) ? (x_init - ONE_INT) : (ONE_INT - x_init);
      stat_r <= operand[31] ? STAT_DOMAIN : ((operand == 32'd0) ? STAT_RANGE : STAT_OK);
    end else if (state == ST_SQRT_WAIT && ustat.done) begin
      x <= ures;
    end else if (state == ST_DIV_WAIT && ustat.done) begin
      mag <= ures;
      n   <= n + N_W'(1);
    end
  end

  // Output register: holds a finished beat until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == ST_FINISH && out_free) begin
        out_valid <= 1'b1;
        log_value <= fin_value;
        status    <= stat_r;
      end
    end
  end

endmodule

// ===== rtl/lbrs_unit.sv =====
// Shared bit-serial unit: restoring square root or restoring division, one bit per cycle.
module lbrs_unit import lbrs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  unit_req_t         req,
  input  logic [WORD_W-1:0] src,
  input  logic [WORD_W-1:0] divisor,
  output unit_stat_t        stat,
  output logic [WORD_W-1:0] result
);

  // The square root takes 48 steps over bit pairs; the division 97 steps over bits.
  localparam logic [6:0] SQRT_STEPS = 7'd48;
  localparam logic [6:0] DIV_STEPS  = 7'd97;

  logic [WORD_W-1:0] rem, acc, sr, dreg;
  logic [6:0]        cnt;
  logic              busy, done;
  unit_op_t          op;

  logic [WORD_W-1:0] rem_sh, trial, rem_next, acc_next;
  logic              take;

  always_comb begin
    if (op == OP_SQRT) begin
      rem_sh = {rem[WORD_W-3:0], sr[WORD_W-1:WORD_W-2]};
      trial  = {acc[WORD_W-3:0], 2'b01};
    end else begin
      rem_sh = {rem[WORD_W-2:0], sr[WORD_W-1]};
      trial  = dreg;
    end
    take     = (rem_sh >= trial);
    rem_next = take ? (rem_sh - trial) : rem_sh;
    acc_next = {acc[WORD_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op   <= req.op;
        cnt  <= (req.op == OP_SQRT) ? SQRT_STEPS : DIV_STEPS;
        rem  <= '0;
        acc  <= '0;
        sr   <= src;
        dreg <= divisor;
      end else if (busy) begin
        rem <= rem_next;
        acc <= acc_next;
        sr  <= (op == OP_SQRT) ? {sr[WORD_W-3:0], 2'b00} : {sr[WORD_W-2:0], 1'b0};
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign result    = acc;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== rtl/lbrs_checker.sv =====
// Port-level checker for the logarithm block, with its bind statement.
module lbrs_checker import lbrs_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] log_value,
  input logic [1:0]  status
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(log_value) && $stable(status))
    else $error("stalled result beat changed");

  a_domain: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_DOMAIN |-> log_value == 32'd0)
    else $error("domain error with nonzero value");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_RANGE |-> log_value == 32'h8000_0000)
    else $error("range error without minus infinity");

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == STAT_OK || status == STAT_DOMAIN || status == STAT_RANGE)
    else $error("undefined status code");

endmodule

bind log_by_repeated_square_root lbrs_checker u_lbrs_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .log_value (log_value),
  .status    (status)
);
